### hdl/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the serially set time-of-day clock.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Item kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Characters of interest on the serial line.
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [7:0] TPS_RESET = 8'd20;
  localparam int         TEXT_LEN  = 8;

  localparam int SEC_LIMIT  = 60;
  localparam int MIN_LIMIT  = 60;
  localparam int HOUR_LIMIT = 24;

  // A parsed field holds at most two decimal digits.
  localparam int VAL_W       = 7;
  localparam int FIELD_COUNT = 3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       second_pulse;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       time_loaded;
    logic [1:0] input_error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;    // apply the accepted item
    logic scan;    // advance the parser by one buffer entry
    logic finish;  // load or reject the parsed time, clear the buffer
    logic emit;    // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic parse_req;
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/ssc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_in_if
// Valid/ready channel carrying one input item (tick or received byte).
// ----------------------------------------------------------------------------
interface ssc_in_if;
  import ssc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ssc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_out_if
// Valid/ready channel carrying one result item of the clock.
// ----------------------------------------------------------------------------
interface ssc_out_if;
  import ssc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ssc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_dp
// Datapath: prescaler, time counters, receive buffer, field parser and the
// output register.
// ----------------------------------------------------------------------------
module ssc_dp #(
  parameter int BUFFER_DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire ssc_pkg::in_item_t  item_i,
  input  wire ssc_pkg::dp_cmd_t   cmd_i,
  output ssc_pkg::dp_status_t     status_o,
  output ssc_pkg::out_item_t      result_o
);
  import ssc_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] TEXT_C  = CW'(TEXT_LEN);

  // Clock state
  logic [7:0] tps_q, tick_q, tick_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] min_q, min_d;
  logic [5:0] sec_q, sec_d;

  // Receive side
  logic [7:0]    buf_q [BUFFER_DEPTH];
  logic [7:0]    buf_d [BUFFER_DEPTH];
  logic [CW-1:0] rcount_q, rcount_d;
  logic          pending_q, pending_d;

  // Parser
  logic [CW-1:0]    pos_q, pos_d;
  logic [1:0]       fld_q, fld_d;
  logic [1:0]       nd_q, nd_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [VAL_W-1:0] vals_q [FIELD_COUNT];
  logic [VAL_W-1:0] vals_d [FIELD_COUNT];

  // Flags of the result under construction
  logic       pulse_q, pulse_d;
  logic       echo_v_q, echo_v_d;
  logic [7:0] echo_b_q, echo_b_d;
  logic       loaded_q, loaded_d;
  logic [1:0] err_q, err_d;

  logic [8:0]       tick_next;
  logic             sec_elapsed;
  logic             filled;
  logic             rx_digit;
  logic [7:0]       cur;
  logic             cur_digit;
  logic             in_field;
  logic [VAL_W-1:0] acc_x10;
  logic             in_range;

  assign tick_next   = {1'b0, tick_q} + 9'd1;
  assign sec_elapsed = tick_next >= {1'b0, tps_q};
  assign filled      = (buf_q[1] != '0) && (buf_q[2] != '0) && (buf_q[3] != '0);
  assign rx_digit    = (item_i.rx_byte >= CHAR_ZERO) && (item_i.rx_byte <= CHAR_NINE);

  assign cur       = (pos_q < DEPTH_C) ? buf_q[pos_q[AW-1:0]] : '0;
  assign cur_digit = (cur >= CHAR_ZERO) && (cur <= CHAR_NINE);
  assign in_field  = (cur != '0) && (cur != CHAR_COLON);
  assign acc_x10   = (acc_q << 3) + (acc_q << 1);
  assign in_range  = (vals_q[0] < VAL_W'(HOUR_LIMIT)) && (vals_q[1] < VAL_W'(MIN_LIMIT)) &&
                     (vals_q[2] < VAL_W'(SEC_LIMIT));

  assign status_o.parse_req = (item_i.cmd == CMD_TICK) && sec_elapsed && pending_q && filled;
  assign status_o.scan_done = (fld_q == 2'(FIELD_COUNT));

  always_comb begin
    tick_d    = tick_q;
    hour_d    = hour_q;
    min_d     = min_q;
    sec_d     = sec_q;
    buf_d     = buf_q;
    rcount_d  = rcount_q;
    pending_d = pending_q;
    pos_d     = pos_q;
    fld_d     = fld_q;
    nd_d      = nd_q;
    acc_d     = acc_q;
    vals_d    = vals_q;
    pulse_d   = pulse_q;
    echo_v_d  = echo_v_q;
    echo_b_d  = echo_b_q;
    loaded_d  = loaded_q;
    err_d     = err_q;

    if (cmd_i.step) begin
      pulse_d  = 1'b0;
      echo_v_d = 1'b0;
      echo_b_d = '0;
      loaded_d = 1'b0;
      err_d    = ERR_NONE;
      pos_d    = '0;
      fld_d    = '0;
      nd_d     = '0;
      acc_d    = '0;
      if (item_i.cmd == CMD_TICK) begin
        if (sec_elapsed) begin
          tick_d  = '0;
          pulse_d = 1'b1;
          if (({1'b0, sec_q} + 7'd1) >= 7'(SEC_LIMIT)) begin
            sec_d = '0;
            if (({1'b0, min_q} + 7'd1) >= 7'(MIN_LIMIT)) begin
              min_d = '0;
              if (({1'b0, hour_q} + 6'd1) >= 6'(HOUR_LIMIT)) begin
                hour_d = '0;
              end else begin
                hour_d = hour_q + 5'd1;
              end
            end else begin
              min_d = min_q + 6'd1;
            end
          end else begin
            sec_d = sec_q + 6'd1;
          end
        end else begin
          tick_d = tick_next[7:0];
        end
      end else begin
        // Any received byte arms a load at the next second.
        pending_d = 1'b1;
        if (item_i.rx_byte == CHAR_NL) begin
          if (rcount_q >= TEXT_C) begin
            rcount_d = '0;
          end
        end else if (rx_digit || (item_i.rx_byte == CHAR_COLON)) begin
          if (rcount_q < DEPTH_C) begin
            buf_d[rcount_q[AW-1:0]] = item_i.rx_byte;
            rcount_d = rcount_q + CW'(1);
            echo_v_d = 1'b1;
            echo_b_d = item_i.rx_byte;
          end else begin
            err_d = ERR_FULL;
          end
        end
      end
    end

    // One buffer entry per cycle: either part of the current field, or the
    // separator (colon, empty entry or end of buffer) that closes it.
    if (cmd_i.scan) begin
      if (in_field) begin
        if (cur_digit && (nd_q < 2'd2)) begin
          acc_d = acc_x10 + VAL_W'(cur[3:0]);
          nd_d  = nd_q + 2'd1;
        end
        pos_d = pos_q + CW'(1);
      end else begin
        if (fld_q < 2'(FIELD_COUNT)) begin
          vals_d[fld_q] = acc_q;
        end
        fld_d = fld_q + 2'd1;
        acc_d = '0;
        nd_d  = '0;
        if (pos_q < DEPTH_C) begin
          pos_d = pos_q + CW'(1);
        end
      end
    end

    if (cmd_i.finish) begin
      if (in_range) begin
        hour_d   = vals_q[0][4:0];
        min_d    = vals_q[1][5:0];
        sec_d    = vals_q[2][5:0];
        loaded_d = 1'b1;
      end else begin
        err_d = ERR_RANGE;
      end
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        buf_d[i] = '0;
      end
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= TPS_RESET;
      tick_q    <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        buf_q[i] <= '0;
      end
      rcount_q  <= '0;
      pending_q <= 1'b0;
      pos_q     <= '0;
      fld_q     <= '0;
      nd_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      tick_q    <= tick_d;
      hour_q    <= hour_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      buf_q     <= buf_d;
      rcount_q  <= rcount_d;
      pending_q <= pending_d;
      pos_q     <= pos_d;
      fld_q     <= fld_d;
      nd_q      <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    vals_q   <= vals_d;
    pulse_q  <= pulse_d;
    echo_v_q <= echo_v_d;
    echo_b_q <= echo_b_d;
    loaded_q <= loaded_d;
    err_q    <= err_d;
    if (cmd_i.emit) begin
      result_o.hour         <= hour_q;
      result_o.minute       <= min_q;
      result_o.second       <= sec_q;
      result_o.second_pulse <= pulse_q;
      result_o.echo_valid   <= echo_v_q;
      result_o.echo_byte    <= echo_b_q;
      result_o.time_loaded  <= loaded_q;
      result_o.input_error  <= err_q;
    end
  end

  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q < 5'(HOUR_LIMIT)) && (min_q < 6'(MIN_LIMIT)) && (sec_q < 6'(SEC_LIMIT)))
    else $error("time counters out of range");

  a_rcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcount_q <= DEPTH_C)
    else $error("receive write position beyond buffer");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !pending_q && (buf_q[1] == '0))
    else $error("buffer not cleared after parse");

endmodule
`default_nettype wire

### hdl/ssc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_ctrl
// Controller: input handshake, parse sequencing and the output register's
// valid flag.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ssc_pkg::dp_status_t  status_i,
  output ssc_pkg::dp_cmd_t          cmd_o
);
  import ssc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  assign cmd_o.step   = accept;
  assign cmd_o.scan   = (state_q == S_SCAN) && !status_i.scan_done;
  assign cmd_o.finish = (state_q == S_SCAN) && status_i.scan_done;
  assign cmd_o.emit   = (state_q == S_EMIT) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = status_i.parse_req ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_plain_item_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status_i.parse_req) |=> (state_q == S_EMIT))
    else $error("item without parse did not go to emit");

  a_parse_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.parse_req) |=> (state_q == S_SCAN))
    else $error("parse request did not start the scan");

  a_emit_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q && (state_q == S_IDLE))
    else $error("emitted result not presented");

endmodule
`default_nettype wire

### hdl/serial_set_time_of_day_clock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_set_time_of_day_clock
// Hours/minutes/seconds clock driven by base-timer ticks and set from
// colon-separated decimal text received over a serial line.
// ----------------------------------------------------------------------------
// Each input transfer is either a base-timer tick or a received byte; each
// gives exactly one result transfer with the time after the item, a second
// pulse, the echoed digit or colon, a load flag and an error code. A tick or a
// byte is applied when it is accepted; the emit state then moves its result
// into the result register once the output register is free, and the block
// returns to idle. A tick that completes a second while a received time is
// pending and buffer entries 1 to 3 are filled also runs the parser. The parser
// walks the receive buffer one entry per cycle, closing each of the three
// fields on a colon, an empty entry or the end of the buffer. The next item is
// accepted as soon as the previous result sits in the output register, even
// while that result waits to be taken. The user must write ticks_per_second
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block itself
// does not enforce this. A value of zero acts as one.
// ----------------------------------------------------------------------------
module serial_set_time_of_day_clock #(
  parameter int BUFFER_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  ssc_in_if.sink          item_i,
  ssc_out_if.source       result_o
);
  import ssc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  ssc_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i.data),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .result_o    (result_o.data)
  );

endmodule
`default_nettype wire

### bench/serial_set_time_of_day_clock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_set_time_of_day_clock_tb
// Self-checking bench for the serially set time-of-day clock. A table of
// directed items comes first: reset values, the full buffer, the hour wrap and
// a rejected time. Random tick and byte traffic follows, mostly well-formed
// time strings followed by enough ticks to reach the next second. Every result
// transfer is checked against its table row or a predictor of the clock and its
// receive buffer. The run steps through several prescaler settings and idling patterns.
// ----------------------------------------------------------------------------
module serial_set_time_of_day_clock_tb;
  import ssc_pkg::*;

  localparam int BUF_DEPTH   = 8;
  localparam int MAX_CYCLES  = 200000;
  localparam int SETTLE      = BUF_DEPTH + 12;
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_ROWS    = 25;
  // Rows before this index run with the prescaler at its reset value.
  localparam int DIR_AT_RESET = 3;

  localparam out_item_t NO_EXP = '0;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } row_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  ssc_in_if  item_ch ();
  ssc_out_if result_ch ();

  serial_set_time_of_day_clock #(.BUFFER_DEPTH(BUF_DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  // Predicted state of the clock.
  logic [7:0] tps_reg;
  logic [7:0] tick_cnt;
  logic [4:0] hh;
  logic [5:0] mm;
  logic [5:0] ss;
  logic [7:0] rx_buf [BUF_DEPTH];
  int         wr_pos;
  logic       load_pend;

  out_item_t  expected_results [$];
  out_item_t  want;
  row_t       dir_rows [DIR_ROWS];

  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  int  hold_left    = 0;
  int  items_sent   = 0;
  int  fail_count   = 0;
  int  cycle_count  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] digit_char(input int d);
    return CHAR_ZERO + 8'(d);
  endfunction

  function automatic logic [7:0] rand_time_char();
    if ($urandom_range(4) == 0)
      return CHAR_COLON;
    return digit_char($urandom_range(9));
  endfunction

  function automatic void count_second();
    ss = ss + 6'd1;
    if (ss >= SEC_LIMIT) begin
      ss = '0;
      mm = mm + 6'd1;
      if (mm >= MIN_LIMIT) begin
        mm = '0;
        hh = hh + 5'd1;
        if (hh >= HOUR_LIMIT)
          hh = '0;
      end
    end
  endfunction

  // Reads up to three colon-separated fields; only the first two digits of a
  // field count, and an empty field reads as zero.
  function automatic bit parse_buffer(output int ph, output int pm, output int ps);
    int pos;
    int v;
    int nd;
    int f;
    int vals [3];
    pos = 0;
    for (f = 0; f < FIELD_COUNT; f++) begin
      v  = 0;
      nd = 0;
      while (pos < BUF_DEPTH && rx_buf[pos] != 8'd0 && rx_buf[pos] != CHAR_COLON) begin
        if (rx_buf[pos] >= CHAR_ZERO && rx_buf[pos] <= CHAR_NINE && nd < 2) begin
          v = v * 10 + int'(rx_buf[pos] - CHAR_ZERO);
          nd++;
        end
        pos++;
      end
      vals[f] = v;
      if (pos < BUF_DEPTH)
        pos++;
    end
    ph = vals[0];
    pm = vals[1];
    ps = vals[2];
    return ph < HOUR_LIMIT && pm < MIN_LIMIT && ps < SEC_LIMIT;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    int        nxt;
    int        ph;
    int        pm;
    int        ps;
    r = '0;
    if (it.cmd == CMD_TICK) begin
      nxt = int'(tick_cnt) + 1;
      // A prescaler limit at or below the count completes the second at once.
      if (nxt >= int'(tps_reg)) begin
        tick_cnt       = '0;
        r.second_pulse = 1'b1;
        count_second();
        if (load_pend && rx_buf[1] != 8'd0 && rx_buf[2] != 8'd0 && rx_buf[3] != 8'd0) begin
          if (parse_buffer(ph, pm, ps)) begin
            hh            = 5'(ph);
            mm            = 6'(pm);
            ss            = 6'(ps);
            r.time_loaded = 1'b1;
          end else begin
            r.input_error = ERR_RANGE;
          end
          foreach (rx_buf[k])
            rx_buf[k] = '0;
          load_pend = 1'b0;
        end
      end else begin
        tick_cnt = 8'(nxt);
      end
    end else begin
      load_pend = 1'b1;
      if (it.rx_byte == CHAR_NL) begin
        if (wr_pos >= TEXT_LEN)
          wr_pos = 0;
      end else if ((it.rx_byte >= CHAR_ZERO && it.rx_byte <= CHAR_NINE) ||
                   it.rx_byte == CHAR_COLON) begin
        if (wr_pos < BUF_DEPTH) begin
          rx_buf[wr_pos] = it.rx_byte;
          wr_pos++;
          r.echo_valid = 1'b1;
          r.echo_byte  = it.rx_byte;
        end else begin
          r.input_error = ERR_FULL;
        end
      end
    end
    r.hour   = hh;
    r.minute = mm;
    r.second = ss;
    return r;
  endfunction

  // Offers one item, waits for its transfer and records what should come back.
  task automatic offer_item(input in_item_t it, input bit use_typed, input out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk_i); while (!item_ch.ready);
    res = predict_result(it);
    expected_results.push_back(use_typed ? typed_res : res);
    items_sent++;
  endtask

  // The register is only written once every result is out and the block idle.
  task automatic set_prescaler(input logic [7:0] value);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    tps_reg = value;
  endtask

  // A time string, with padding and a newline first where the write position
  // needs rewinding, then enough ticks to reach the next second.
  task automatic send_time_text();
    logic [7:0] text [$];
    int         val;
    int         nd;
    int         fields;
    int         f;
    int         n_ticks;
    if (wr_pos > 0 && wr_pos < TEXT_LEN)
      repeat (TEXT_LEN - wr_pos) text.push_back(rand_time_char());
    if (text.size() != 0 || wr_pos >= TEXT_LEN || $urandom_range(1) == 0)
      text.push_back(CHAR_NL);
    fields = ($urandom_range(9) == 0) ? 2 : 3;
    for (f = 0; f < fields; f++) begin
      if (f > 0)
        text.push_back(CHAR_COLON);
      val = (f == 0) ? $urandom_range(27) : $urandom_range(63);
      case ($urandom_range(7))
        0: nd = 0;
        1: nd = 1;
        2: nd = 3;
        default: nd = 2;
      endcase
      if (nd == 1)
        text.push_back(digit_char(val % 10));
      if (nd >= 2) begin
        text.push_back(digit_char(val / 10));
        text.push_back(digit_char(val % 10));
      end
      if (nd == 3)
        text.push_back(digit_char($urandom_range(9)));
    end
    if ($urandom_range(1) == 0)
      text.push_back(CHAR_NL);
    foreach (text[i])
      offer_item({CMD_BYTE, text[i]}, 1'b0, NO_EXP);
    n_ticks = (int'(tps_reg) <= int'(tick_cnt) + 1) ? 1 : int'(tps_reg) - int'(tick_cnt);
    n_ticks += $urandom_range(2);
    repeat (n_ticks) offer_item({CMD_TICK, 8'($urandom)}, 1'b0, NO_EXP);
  endtask

  task automatic run_phase(input logic [7:0] tps, input int src_pct, input int snk_pct,
                           input int budget, input bit hold);
    int start;
    set_prescaler(tps);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    hold_req     = hold;
    start        = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(99) < 75) begin
        send_time_text();
      end else begin
        case ($urandom_range(3))
          0: offer_item({CMD_TICK, 8'($urandom)}, 1'b0, NO_EXP);
          1: offer_item({CMD_BYTE, 8'($urandom)}, 1'b0, NO_EXP);
          2: offer_item({CMD_BYTE, rand_time_char()}, 1'b0, NO_EXP);
          default: offer_item({CMD_BYTE, CHAR_NL}, 1'b0, NO_EXP);
        endcase
      end
    end
  endtask

  // Receiver side, including the one long hold-off that backs the block up.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (!rst_ni) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result transfer: %0d:%0d:%0d", result_ch.data.hour,
                   result_ch.data.minute, result_ch.data.second);
      end else begin
        want = expected_results.pop_front();
        if (result_ch.data.hour !== want.hour || result_ch.data.minute !== want.minute ||
            result_ch.data.second !== want.second ||
            result_ch.data.second_pulse !== want.second_pulse ||
            result_ch.data.echo_valid !== want.echo_valid ||
            result_ch.data.echo_byte !== want.echo_byte ||
            result_ch.data.time_loaded !== want.time_loaded ||
            result_ch.data.input_error !== want.input_error) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: expected %0d:%0d:%0d pls %b echo %b/%h load %b err %0d, %s",
                     want.hour, want.minute, want.second, want.second_pulse,
                     want.echo_valid, want.echo_byte, want.time_loaded, want.input_error,
                     $sformatf("got %0d:%0d:%0d pls %b echo %b/%h load %b err %0d",
                               result_ch.data.hour, result_ch.data.minute,
                               result_ch.data.second, result_ch.data.second_pulse,
                               result_ch.data.echo_valid, result_ch.data.echo_byte,
                               result_ch.data.time_loaded, result_ch.data.input_error));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    tps_reg   = TPS_RESET;
    tick_cnt  = '0;
    hh        = '0;
    mm        = '0;
    ss        = '0;
    wr_pos    = 0;
    load_pend = 1'b0;
    foreach (rx_buf[k])
      rx_buf[k] = '0;

    // Fields: cmd, byte, typed, then hour, minute, second, pulse, echo, echo byte,
    // loaded, error.
    dir_rows = '{
      {CMD_TICK, 8'h00, 1'b1, {5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      {CMD_BYTE, 8'h00, 1'b1, {5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      {CMD_BYTE, CHAR_NL, 1'b1, {5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      // Prescaler now at the tick count; the buffer is pending but empty.
      {CMD_TICK, 8'h00, 1'b1, {5'd0, 6'd0, 6'd1, 1'b1, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      {CMD_BYTE, CHAR_ZERO + 8'd2, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd3, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_COLON, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd5, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_NINE, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_COLON, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd5, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_NINE, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO, 1'b1, {5'd0, 6'd0, 6'd1, 1'b0, 1'b0, 8'h00, 1'b0, ERR_FULL}},
      {CMD_BYTE, CHAR_NL, 1'b0, NO_EXP},
      {CMD_TICK, 8'hFF, 1'b1, {5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 8'h00, 1'b1, ERR_NONE}},
      {CMD_TICK, 8'h00, 1'b1, {5'd0, 6'd0, 6'd0, 1'b1, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      // One-digit hour, then a three-digit minute that reads as 75.
      {CMD_BYTE, CHAR_NINE, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_COLON, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd7, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd5, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_ZERO + 8'd1, 1'b0, NO_EXP},
      {CMD_TICK, 8'h00, 1'b1, {5'd0, 6'd0, 6'd1, 1'b1, 1'b0, 8'h00, 1'b0, ERR_RANGE}},
      {CMD_BYTE, 8'hFF, 1'b0, NO_EXP},
      {CMD_TICK, 8'h00, 1'b0, NO_EXP},
      {CMD_BYTE, CHAR_NL, 1'b0, NO_EXP}
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_AT_RESET)
        set_prescaler(8'd1);
      offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // The first phase also holds the receiver off once, long enough to back the block up.
    run_phase(8'd1, 0, 0, 80, 1'b1);
    run_phase(8'd0, 87, 0, 50, 1'b0);
    run_phase(8'd4, 0, 87, 80, 1'b0);
    run_phase(8'd255, 16, 16, 200, 1'b0);

    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/ssc_pkg.sv
hdl/ssc_in_if.sv
hdl/ssc_out_if.sv
hdl/ssc_dp.sv
hdl/ssc_ctrl.sv
hdl/serial_set_time_of_day_clock.sv
bench/serial_set_time_of_day_clock_tb.sv
